/* design/hxc_pkg.sv */
package hxc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 32;

  localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;

  localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_HI = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_LO = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_HI = 8'h46;
  localparam logic [NIB_W-1:0]  NIB_TEN       = 4'h a;

  typedef struct packed {
    logic             push;
    logic [CRC_W-1:0] data;
  } buf_push_t;

endpackage

/* design/hxc_if.sv */
interface hxc_in_if import hxc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              has_char;
  logic              last_char;

  modport source (output valid, output char_code, output has_char, output last_char,
                  input ready);
  modport sink (input valid, input char_code, input has_char, input last_char,
                output ready);
endinterface

interface hxc_out_if import hxc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CRC_W-1:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

/* design/hxc_hex_decode.sv */
module hxc_hex_decode import hxc_pkg::*; (
  input  logic [CHAR_W-1:0] char_code,
  output logic              nib_valid,
  output logic [NIB_W-1:0]  nib
);

  logic [CHAR_W-1:0] diff_digit;
  logic [CHAR_W-1:0] diff_lower;
  logic [CHAR_W-1:0] diff_upper;

  assign diff_digit = char_code - CHAR_DIGIT_LO;
  assign diff_lower = char_code - CHAR_LOWER_LO;
  assign diff_upper = char_code - CHAR_UPPER_LO;

  always_comb begin
    nib_valid = 1'b0;
    nib       = '0;
    if (char_code >= CHAR_DIGIT_LO && char_code <= CHAR_DIGIT_HI) begin
      nib_valid = 1'b1;
      nib       = diff_digit[NIB_W-1:0];
    end else if (char_code >= CHAR_LOWER_LO && char_code <= CHAR_LOWER_HI) begin
      nib_valid = 1'b1;
      nib       = diff_lower[NIB_W-1:0] + NIB_TEN;
    end else if (char_code >= CHAR_UPPER_LO && char_code <= CHAR_UPPER_HI) begin
      nib_valid = 1'b1;
      nib       = diff_upper[NIB_W-1:0] + NIB_TEN;
    end
  end

endmodule

/* design/hxc_crc_byte.sv */
module hxc_crc_byte import hxc_pkg::*; (
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [BYTE_W-1:0] data,
  output logic [CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

/* design/hxc_out_buf.sv */
module hxc_out_buf import hxc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  buf_push_t wr,
  output logic      full,
  hxc_out_if.source out_ch
);

  logic [1:0]       cnt_r, cnt_nxt;
  logic [CRC_W-1:0] data0_r, data0_nxt;
  logic [CRC_W-1:0] data1_r, data1_nxt;
  logic             pop;

  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.crc_value = data0_r;
  assign full             = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt   = cnt_r;
    data0_nxt = data0_r;
    data1_nxt = data1_r;
    if (pop && wr.push) begin
      if (cnt_r == 2'd1) begin
        data0_nxt = wr.data;
      end else begin
        data0_nxt = data1_r;
        data1_nxt = wr.data;
      end
    end else if (pop) begin
      data0_nxt = data1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (wr.push) begin
      if (cnt_r == 2'd0) begin
        data0_nxt = wr.data;
      end else begin
        data1_nxt = wr.data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    data0_r <= data0_nxt;
    data1_r <= data1_nxt;
  end

endmodule

/* design/hex_text_crc32.sv */
// CRC-32 (reflected, polynomial EDB88320, preset and final inversion) over a
// byte string given as ASCII hex text, one character per transfer. Positions
// pair up into bytes; a character that is not a hex digit holds its place but
// adds no nibble. One character is taken every cycle while the result queue has
// room: the nibble decode and the eight CRC bit steps for a completed byte sit
// between the state registers and the result queue. The item marked last makes
// one result, registered into the result queue and shown on out_ch once any
// results ahead of it have been taken; the two-entry queue keeps input flowing
// while results wait, and in_ch drops ready only while both entries are full.
module hex_text_crc32 import hxc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hxc_in_if.sink    in_ch,
  hxc_out_if.source out_ch
);

  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] pair_r, pair_nxt;
  logic              second_r, second_nxt;

  logic              accept;
  logic              full;
  logic              nib_valid;
  logic [NIB_W-1:0]  nib;
  logic [BYTE_W-1:0] byte_done;
  logic [CRC_W-1:0]  crc_upd;
  buf_push_t         wr;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;

  hxc_hex_decode u_dec (
    .char_code (in_ch.char_code),
    .nib_valid (nib_valid),
    .nib       (nib)
  );

  assign byte_done = nib_valid ? {pair_r[NIB_W-1:0], nib} : pair_r;

  hxc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data    (byte_done),
    .crc_out (crc_upd)
  );

  always_comb begin
    crc_nxt    = crc_r;
    pair_nxt   = pair_r;
    second_nxt = second_r;
    wr.push    = 1'b0;
    if (accept && in_ch.has_char) begin
      if (!second_r) begin
        pair_nxt   = nib_valid ? {{(BYTE_W-NIB_W){1'b0}}, nib} : '0;
        second_nxt = 1'b1;
      end else begin
        pair_nxt   = byte_done;
        crc_nxt    = crc_upd;
        second_nxt = 1'b0;
      end
    end
    wr.data = ~crc_nxt;
    if (accept && in_ch.last_char) begin
      wr.push    = 1'b1;
      crc_nxt    = CRC_PRESET;
      pair_nxt   = '0;
      second_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_PRESET;
      pair_r   <= '0;
      second_r <= 1'b0;
    end else begin
      crc_r    <= crc_nxt;
      pair_r   <= pair_nxt;
      second_r <= second_nxt;
    end
  end

  hxc_out_buf u_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .full   (full),
    .out_ch (out_ch)
  );

endmodule

/* bench/hex_text_crc32_tb.sv */
module hex_text_crc32_tb;
  import hxc_pkg::*;

  localparam int ITEM_TARGET = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  class crc_scoreboard;
    logic [CRC_W-1:0]  crc_run;
    logic [BYTE_W-1:0] pair_byte;
    bit                second_half;
    logic [CRC_W-1:0]  crc_due[$];
    int                errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      crc_run     = CRC_PRESET;
      pair_byte   = '0;
      second_half = 1'b0;
    endfunction

    function bit hex_value(input logic [CHAR_W-1:0] c, output logic [NIB_W-1:0] nib);
      nib = '0;
      if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
        nib = NIB_W'(c - CHAR_DIGIT_LO);
        return 1'b1;
      end
      if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
        nib = NIB_W'(c - CHAR_LOWER_LO) + NIB_TEN;
        return 1'b1;
      end
      if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
        nib = NIB_W'(c - CHAR_UPPER_LO) + NIB_TEN;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                          input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < 8; k++) begin
        if (c[0]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    function void note_char(input logic [CHAR_W-1:0] c, input bit has, input bit last);
      logic [NIB_W-1:0] nib;
      bit               ok;
      if (has) begin
        ok = hex_value(c, nib);
        if (!second_half) begin
          pair_byte   = ok ? {{(BYTE_W-NIB_W){1'b0}}, nib} : '0;
          second_half = 1'b1;
        end else begin
          if (ok) pair_byte = {pair_byte[NIB_W-1:0], nib};
          crc_run     = crc_update(crc_run, pair_byte);
          second_half = 1'b0;
        end
      end
      if (last) begin
        crc_due.push_back(~crc_run);
        restart();
      end
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_crc(input logic [CRC_W-1:0] got);
      logic [CRC_W-1:0] want;
      if (crc_due.size() == 0) begin
        report($sformatf("unexpected crc %h", got));
      end else begin
        want = crc_due.pop_front();
        if (got !== want) report($sformatf("crc_value got %h, expected %h", got, want));
      end
    endtask

    function int pending();
      return crc_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hxc_in_if  in_ch();
  hxc_out_if out_ch();

  hex_text_crc32 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  crc_scoreboard     crc_book;
  logic [CHAR_W-1:0] text_q[$];
  int                items_sent;
  int                in_gap_max;
  int                out_stall_max;
  int                cycle_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= rst_n;
      end
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
        crc_book.check_crc(out_ch.crc_value);
        stall = $urandom_range(0, out_stall_max);
      end
    end
  end

  function automatic logic [CHAR_W-1:0] hex_char();
    int idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) return CHAR_DIGIT_LO + CHAR_W'(idx);
    if (idx < 16) return CHAR_LOWER_LO + CHAR_W'(idx - 10);
    return CHAR_UPPER_LO + CHAR_W'(idx - 16);
  endfunction

  task automatic send_item(input logic [CHAR_W-1:0] c, input bit has, input bit last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.has_char  <= has;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    crc_book.note_char(c, has, last);
    if (has || last) items_sent++;
    @(negedge clk);
  endtask

  // close on the final character, or on a separate empty transfer
  task automatic send_text(input bit empty_end, input int noise_pct);
    for (int i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(CHAR_W'($urandom), 1'b0, 1'b0);
      send_item(text_q[i], 1'b1, !empty_end && i == text_q.size() - 1);
    end
    if (empty_end || text_q.size() == 0) send_item(CHAR_W'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int pick;
    bit paused;
    crc_book        = new();
    items_sent      = 0;
    cycle_count     = 0;
    in_gap_max      = 6;
    out_stall_max   = 6;
    paused          = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.has_char  = 1'b0;
    in_ch.last_char = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    text_q = {};
    send_text(1'b1, 0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    text_q = '{8'h30, 8'h39};
    send_text(1'b0, 0);
    text_q = '{8'h61, 8'h66, 8'h41, 8'h46};
    send_text(1'b0, 0);
    text_q = '{8'h2f, 8'h3a};
    send_text(1'b1, 0);
    text_q = '{8'h60, 8'h67, 8'h40, 8'h47};
    send_text(1'b0, 0);
    text_q = '{8'h00, 8'hff};
    send_text(1'b0, 0);
    text_q = '{8'h35, 8'h00, 8'hff, 8'h37};
    send_text(1'b0, 0);
    text_q = '{8'h63};
    send_text(1'b0, 0);
    text_q = '{8'h33, 8'h64, 8'h45};
    send_text(1'b1, 0);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 6;
        out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      end
      if (!paused && items_sent > ITEM_TARGET / 2) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        while (crc_book.pending() != 0) @(posedge clk);
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) len = $urandom_range(0, 1);
      else if (pick < 90) len = $urandom_range(2, 16);
      else len = $urandom_range(17, 40);
      text_q = {};
      repeat (len) begin
        if ($urandom_range(0, 99) < 85) text_q.push_back(hex_char());
        else text_q.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      send_text(1'(($urandom_range(0, 1))), 8);
    end
    in_ch.valid <= 1'b0;

    while (crc_book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (crc_book.pending() != 0) crc_book.report("results still outstanding");
    if (crc_book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
